[rtl/core/nls_pkg.sv]
// ----------------------------------------------------------------------------
// nls_pkg
// Types and character codes shared by the number literal scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_OVERLONG  = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef struct packed {
    logic       kind;
    logic [7:0] character;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       sign_present;
    logic [7:0] integral_digits;
    logic [7:0] integral_leading_zeros;
    logic       point_present;
    logic [7:0] fraction_digits;
    logic [7:0] fraction_trailing_zeros;
    logic       exponent_marker;
    logic       exponent_sign_present;
    logic [7:0] exponent_digits;
    logic [7:0] exponent_leading_zeros;
  } result_t;

  // one-hot parse phases
  typedef enum logic [5:0] {
    PH_START      = 6'b000001,
    PH_INT        = 6'b000010,
    PH_FRAC       = 6'b000100,
    PH_EXP_START  = 6'b001000,
    PH_EXP_DIGITS = 6'b010000,
    PH_DEAD       = 6'b100000
  } phase_e;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    is_sign = (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_marker(input logic [7:0] c);
    is_marker = (c == CH_LOW_E) || (c == CH_UP_E) || (c == CH_CARET);
  endfunction

endpackage

`default_nettype wire

[rtl/core/nls_if.sv]
// ----------------------------------------------------------------------------
// nls_item_if / nls_result_if
// Valid/ready channels for literal words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface nls_item_if;
  import nls_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nls_result_if;
  import nls_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/nls_parser.sv]
// ----------------------------------------------------------------------------
// nls_parser
// Grammar state and digit counters; one word per step, result on end word.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_parser
  import nls_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 255
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  output result_t      result_o
);

  localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
  localparam logic [CW-1:0] MaxLen = CW'(MAX_LENGTH);

  phase_e        phase_q, phase_d;
  logic          bad_q, bad_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          long_q, long_d;
  logic          sign_q, sign_d;
  logic [7:0]    int_cnt_q, int_cnt_d;
  logic [7:0]    int_zero_q, int_zero_d;
  logic          int_nz_q, int_nz_d;
  logic          point_q, point_d;
  logic [7:0]    frac_cnt_q, frac_cnt_d;
  logic [7:0]    frac_run_q, frac_run_d;
  logic          mark_q, mark_d;
  logic          esign_q, esign_d;
  logic [7:0]    exp_cnt_q, exp_cnt_d;
  logic [7:0]    exp_zero_q, exp_zero_d;
  logic          exp_nz_q, exp_nz_d;

  logic [7:0] c;
  logic       c_digit, c_zero;

  assign c       = item_i.character;
  assign c_digit = is_digit(c);
  assign c_zero  = (c == CH_ZERO);

  always_comb begin
    phase_d    = phase_q;
    bad_d      = bad_q;
    cnt_d      = cnt_q;
    long_d     = long_q;
    sign_d     = sign_q;
    int_cnt_d  = int_cnt_q;
    int_zero_d = int_zero_q;
    int_nz_d   = int_nz_q;
    point_d    = point_q;
    frac_cnt_d = frac_cnt_q;
    frac_run_d = frac_run_q;
    mark_d     = mark_q;
    esign_d    = esign_q;
    exp_cnt_d  = exp_cnt_q;
    exp_zero_d = exp_zero_q;
    exp_nz_d   = exp_nz_q;

    if (step_i) begin
      if (item_i.kind == KIND_END) begin
        // literal closed, start afresh
        phase_d    = PH_START;
        bad_d      = 1'b0;
        cnt_d      = '0;
        long_d     = 1'b0;
        sign_d     = 1'b0;
        int_cnt_d  = '0;
        int_zero_d = '0;
        int_nz_d   = 1'b0;
        point_d    = 1'b0;
        frac_cnt_d = '0;
        frac_run_d = '0;
        mark_d     = 1'b0;
        esign_d    = 1'b0;
        exp_cnt_d  = '0;
        exp_zero_d = '0;
        exp_nz_d   = 1'b0;
      end else if (cnt_q >= MaxLen) begin
        long_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        case (phase_q)
          PH_START, PH_INT: begin
            phase_d = PH_INT;
            if ((phase_q == PH_START) && is_sign(c)) begin
              sign_d = 1'b1;
            end else if (c_digit) begin
              int_cnt_d = sat_inc(int_cnt_q);
              if (c_zero && !int_nz_q) begin
                int_zero_d = sat_inc(int_zero_q);
              end else begin
                int_nz_d = 1'b1;
              end
            end else if (c == CH_POINT) begin
              point_d = 1'b1;
              phase_d = PH_FRAC;
            end else if (is_marker(c)) begin
              mark_d  = 1'b1;
              phase_d = PH_EXP_START;
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_DEAD;
            end
          end
          PH_FRAC: begin
            if (c_digit) begin
              frac_cnt_d = sat_inc(frac_cnt_q);
              frac_run_d = c_zero ? sat_inc(frac_run_q) : 8'd0;
            end else if (is_marker(c)) begin
              mark_d  = 1'b1;
              phase_d = PH_EXP_START;
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_DEAD;
            end
          end
          PH_EXP_START, PH_EXP_DIGITS: begin
            phase_d = PH_EXP_DIGITS;
            if ((phase_q == PH_EXP_START) && is_sign(c)) begin
              esign_d = 1'b1;
            end else if (c_digit) begin
              exp_cnt_d = sat_inc(exp_cnt_q);
              if (c_zero && !exp_nz_q) begin
                exp_zero_d = sat_inc(exp_zero_q);
              end else begin
                exp_nz_d = 1'b1;
              end
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_DEAD;
            end
          end
          default: begin
            phase_d = PH_DEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      bad_q      <= 1'b0;
      cnt_q      <= '0;
      long_q     <= 1'b0;
      sign_q     <= 1'b0;
      int_cnt_q  <= '0;
      int_zero_q <= '0;
      int_nz_q   <= 1'b0;
      point_q    <= 1'b0;
      frac_cnt_q <= '0;
      frac_run_q <= '0;
      mark_q     <= 1'b0;
      esign_q    <= 1'b0;
      exp_cnt_q  <= '0;
      exp_zero_q <= '0;
      exp_nz_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bad_q      <= bad_d;
      cnt_q      <= cnt_d;
      long_q     <= long_d;
      sign_q     <= sign_d;
      int_cnt_q  <= int_cnt_d;
      int_zero_q <= int_zero_d;
      int_nz_q   <= int_nz_d;
      point_q    <= point_d;
      frac_cnt_q <= frac_cnt_d;
      frac_run_q <= frac_run_d;
      mark_q     <= mark_d;
      esign_q    <= esign_d;
      exp_cnt_q  <= exp_cnt_d;
      exp_zero_q <= exp_zero_d;
      exp_nz_q   <= exp_nz_d;
    end
  end

  always_comb begin
    if (long_q) begin
      result_o.status = ST_OVERLONG;
    end else if (bad_q || (cnt_q == '0) || ((int_cnt_q == '0) && (frac_cnt_q == '0)) ||
                 (mark_q && (exp_cnt_q == '0))) begin
      result_o.status = ST_MALFORMED;
    end else begin
      result_o.status = ST_OK;
    end
    result_o.sign_present            = sign_q;
    result_o.integral_digits         = int_cnt_q;
    result_o.integral_leading_zeros  = int_zero_q;
    result_o.point_present           = point_q;
    result_o.fraction_digits         = frac_cnt_q;
    result_o.fraction_trailing_zeros = frac_run_q;
    result_o.exponent_marker         = mark_q;
    result_o.exponent_sign_present   = esign_q;
    result_o.exponent_digits         = exp_cnt_q;
    result_o.exponent_leading_zeros  = exp_zero_q;
  end

endmodule

`default_nettype wire

[rtl/core/number_literal_scanner_unit.sv]
// ----------------------------------------------------------------------------
// number_literal_scanner_unit
// Checks a decimal number literal word by word and reports digit counts.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | produces
//  in_i    | in  | kind, character              | one word per literal byte/end
//  out_o   | out | status, 6 counts, 4 flags    | one word per end word
//
//  one word is taken every cycle unless the input stalls; each word passes the input
//  register, and an end word's result is loaded into the result register as it leaves
//  reset clears the parse state and the input and result valid flags
//  only an end word waiting on a full, stalled result register holds the input
// ----------------------------------------------------------------------------
`default_nettype none

module number_literal_scanner_unit
  import nls_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 255
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  nls_item_if.sink     in_i,
  nls_result_if.source out_o
);

  logic    st_valid_q;
  item_t   st_item_q;
  logic    st_adv;
  logic    res_valid_q;
  result_t res_q;
  result_t parse_res;

  assign st_adv     = st_valid_q && ((st_item_q.kind == KIND_CHAR) || !res_valid_q ||
                                     out_o.ready);
  assign in_i.ready = !st_valid_q || st_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      st_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      st_item_q <= in_i.payload;
    end
  end

  nls_parser #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (st_adv),
    .item_i   (st_item_q),
    .result_o (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (st_adv && (st_item_q.kind == KIND_END)) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_adv && (st_item_q.kind == KIND_END)) begin
      res_q <= parse_res;
    end
  end

  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

  // a result appears only after an end word left the input register
  a_res_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(st_adv && (st_item_q.kind == KIND_END)))
    else $error("result without end word");

  // input stalls only behind an end word and a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (st_valid_q && (st_item_q.kind == KIND_END) && res_valid_q &&
                     !out_o.ready))
    else $error("input stalled without cause");

  // an accepted literal carries at least one significand digit
  a_ok_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == ST_OK)) |->
      ((res_q.integral_digits != 8'd0) || (res_q.fraction_digits != 8'd0)))
    else $error("valid literal without digits");

  // no status code beyond the defined three
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.status == ST_OK) || (res_q.status == ST_MALFORMED) ||
                     (res_q.status == ST_OVERLONG)))
    else $error("undefined status");

endmodule

`default_nettype wire
